@@ src/htm_pkg.sv @@
package htm_pkg;

  // Tallest column the class store can hold.
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  // The store is split by row parity into two memories of half the depth.
  localparam int HALF_DEPTH = MAX_ROWS / 2;
  localparam int HALF_W     = $clog2(HALF_DEPTH);

  // Field and register widths.
  localparam int PIX_W      = 16;
  localparam int LEN_W      = 11;
  localparam int COL_W      = 16;
  localparam int LEN_RESET  = 1024;

  // Item kinds on the input channel.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOW     = 2'd0,
    REG_HIGH    = 2'd1,
    REG_COL_LEN = 2'd2,
    REG_COL_CNT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_BG     = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } class_t;

  // One store row: the class of that row in the even-column bank (low half)
  // and in the odd-column bank (high half).
  typedef logic [3:0] word_t;

  // Request handed from the accept stage to the class store.
  typedef struct packed {
    logic             valid;
    logic             want_res;
    logic             write;
    logic [ROW_W-1:0] row;
    logic             dec_bank;
    logic             wr_bank;
    logic             has_left;
    logic             up_ok;
    logic             dn_ok;
    class_t           right;
    logic             last;
  } req_t;

  // Result coming back from the class store.
  typedef struct packed {
    logic valid;
    logic edge_res;
    logic last;
  } res_t;

endpackage

@@ src/htm_store.sv @@
module htm_store
  import htm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  req_t req,
  output res_t res
);

  function automatic class_t word_class(word_t w, logic bank);
    return class_t'(bank ? w[3:2] : w[1:0]);
  endfunction

  function automatic word_t word_merge(word_t w, logic bank, class_t c);
    return bank ? {c, w[1:0]} : {w[3:2], c};
  endfunction

  // Even rows live in mem_even, odd rows in mem_odd, at index row/2.
  word_t mem_even [HALF_DEPTH];
  word_t mem_odd  [HALF_DEPTH];

  logic [HALF_W-1:0] half_a;
  logic [HALF_W-1:0] half_prv;
  logic [HALF_W-1:0] half_nxt;

  word_t rd_even0_r, rd_even1_r, rd_odd0_r, rd_odd1_r;

  req_t             req_r;
  logic             fwd_valid_r;
  logic [ROW_W-1:0] fwd_row_r;
  word_t            fwd_word_r;

  word_t            cur_raw, up_raw, dn_raw;
  word_t            cur_w, up_w, dn_w;
  logic [ROW_W-1:0] up_row, dn_row;
  class_t           cls_c, cls_l, cls_u, cls_d;
  logic             keep;
  word_t            new_word;
  logic             wr_en, we_even, we_odd;

  // Fixed port addresses: an even row reads odd rows around it through the
  // odd memory, an odd row reads even rows around it through the even one.
  assign half_a   = req.row[ROW_W-1:1];
  assign half_prv = half_a - 1'b1;
  assign half_nxt = half_a + 1'b1;

  always_ff @(posedge clk) begin
    if (we_even) begin
      mem_even[req_r.row[ROW_W-1:1]] <= new_word;
    end
    rd_even0_r <= mem_even[half_a];
    rd_even1_r <= mem_even[half_nxt];
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      mem_odd[req_r.row[ROW_W-1:1]] <= new_word;
    end
    rd_odd0_r <= mem_odd[half_prv];
    rd_odd1_r <= mem_odd[half_a];
  end

  always_comb begin
    cur_raw = req_r.row[0] ? rd_odd1_r  : rd_even0_r;
    up_raw  = req_r.row[0] ? rd_even0_r : rd_odd0_r;
    dn_raw  = req_r.row[0] ? rd_even1_r : rd_odd1_r;

    up_row = req_r.row - 1'b1;
    dn_row = req_r.row + 1'b1;

    // The write of the previous request landed on the same edge as these
    // reads, so its word is taken from the bypass register instead.
    cur_w = (fwd_valid_r && fwd_row_r == req_r.row) ? fwd_word_r : cur_raw;
    up_w  = (fwd_valid_r && fwd_row_r == up_row)    ? fwd_word_r : up_raw;
    dn_w  = (fwd_valid_r && fwd_row_r == dn_row)    ? fwd_word_r : dn_raw;

    cls_c = word_class(cur_w, req_r.dec_bank);
    cls_l = word_class(cur_w, ~req_r.dec_bank);
    cls_u = word_class(up_w, req_r.dec_bank);
    cls_d = word_class(dn_w, req_r.dec_bank);

    keep = (cls_c == CLS_STRONG) ||
           ((cls_c == CLS_WEAK) &&
            ((req_r.right == CLS_STRONG) ||
             (req_r.up_ok && cls_u == CLS_STRONG) ||
             (req_r.dn_ok && cls_d == CLS_STRONG) ||
             (req_r.has_left && cls_l == CLS_STRONG)));

    new_word = word_merge(cur_w, req_r.wr_bank, req_r.right);
  end

  assign wr_en   = req_r.valid && req_r.write;
  assign we_even = wr_en && !req_r.row[0];
  assign we_odd  = wr_en && req_r.row[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      req_r       <= req;
      fwd_valid_r <= wr_en;
    end
    fwd_row_r  <= req_r.row;
    fwd_word_r <= new_word;
  end

  assign res.valid    = req_r.valid && req_r.want_res;
  assign res.edge_res = keep;
  assign res.last     = req_r.last;

endmodule

@@ src/hysteresis_threshold_mask.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_op, in_pixel
// out_      output     out_valid / out_ready  out_edge_res, out_last
// cfg_      input      cfg_wr_en              cfg_index, cfg_data
//
// One item is accepted per cycle while in_ready is high; a result leaves the
// output after the class-store read register and then the output queue.
// Each item reads three store rows through the two read ports of the two
// row-parity memories, and a pixel writes one back, so the store never stalls.
// Reset is synchronous and clears only control state; the class store has no
// clearing pass, since every entry is written before it is read.
// A stalled output fills a three-entry queue, and in_ready drops only when the
// queue cannot take both the result in flight and that of one more item.
module hysteresis_threshold_mask
  import htm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [PIX_W-1:0] in_pixel,

  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_edge_res,
  output logic             out_last,

  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [PIX_W-1:0] cfg_data
);

  typedef struct packed {
    logic edge_res;
    logic last;
  } out_item_t;

  localparam int FIFO_DEPTH = 3;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Configuration registers.
  logic [PIX_W-1:0] low_r, high_r;
  logic [LEN_W-1:0] col_len_r;
  logic [COL_W-1:0] col_cnt_r;

  // Scan position and the number of last-column results still to drain.
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [LEN_W-1:0] pend_r, pend_nxt;

  // Output queue.
  out_item_t         fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] fifo_wr_r, fifo_rd_r;
  logic [FCNT_W-1:0] fifo_cnt_r;
  logic              fifo_push, fifo_pop;

  logic             in_fire;
  logic [LEN_W-1:0] len_eff;
  logic [COL_W-1:0] cnt_eff;
  class_t           pix_cls;
  logic [LEN_W-1:0] row_inc;
  logic [COL_W:0]   col_inc;
  logic [LEN_W-1:0] pend_cut;
  logic [LEN_W-1:0] drain_row;
  req_t             req;
  res_t             res;

  assign in_fire = in_valid && in_ready;

  // Configuration writes must wait for idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= '0;
      high_r    <= '1;
      col_len_r <= LEN_W'(LEN_RESET);
      col_cnt_r <= COL_W'(1);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW:     low_r     <= cfg_data;
        REG_HIGH:    high_r    <= cfg_data;
        REG_COL_LEN: col_len_r <= cfg_data[LEN_W-1:0];
        REG_COL_CNT: col_cnt_r <= cfg_data[COL_W-1:0];
      endcase
    end
  end

  // Accept stage: classify the pixel, work out which store rows and banks the
  // decision needs, and advance the scan position. None of this depends on
  // store contents, so the position moves at the accept edge itself.
  always_comb begin
    // The column length is clamped into the store; a zero count means one.
    if (col_len_r < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (col_len_r > LEN_W'(MAX_ROWS)) begin
      len_eff = LEN_W'(MAX_ROWS);
    end else begin
      len_eff = col_len_r;
    end
    cnt_eff = (col_cnt_r == '0) ? COL_W'(1) : col_cnt_r;

    // Low threshold wins when the thresholds cross; a zero pixel is never weak.
    if (in_pixel < low_r) begin
      pix_cls = CLS_BG;
    end else if (in_pixel > high_r) begin
      pix_cls = CLS_STRONG;
    end else if (in_pixel != '0) begin
      pix_cls = CLS_WEAK;
    end else begin
      pix_cls = CLS_BG;
    end

    row_inc   = {{(LEN_W-ROW_W){1'b0}}, row_pos_r} + 1'b1;
    col_inc   = {1'b0, col_pos_r} + 1'b1;
    pend_cut  = (pend_r > len_eff) ? len_eff : pend_r;
    drain_row = len_eff - pend_cut;

    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    pend_nxt    = pend_r;
    req         = '0;

    if (in_fire) begin
      unique case (op_t'(in_op))
        OP_PIXEL: begin
          // The pixel decides the column before it and is stored in its own
          // column's bank; the column two back shares that bank and is read
          // as the left neighbor before the write.
          req.valid    = 1'b1;
          req.want_res = (col_pos_r != '0);
          req.write    = 1'b1;
          req.row      = row_pos_r;
          req.dec_bank = ~col_pos_r[0];
          req.wr_bank  = col_pos_r[0];
          req.has_left = (col_pos_r > COL_W'(1));
          req.up_ok    = (row_pos_r != '0);
          req.dn_ok    = (row_inc < len_eff);
          req.right    = pix_cls;
          req.last     = 1'b0;

          // A pixel drops any results still waiting to be drained.
          pend_nxt = '0;
          if (row_inc < len_eff) begin
            row_pos_nxt = row_inc[ROW_W-1:0];
          end else begin
            row_pos_nxt = '0;
            if (col_inc >= {1'b0, cnt_eff}) begin
              col_pos_nxt = '0;
              pend_nxt    = len_eff;
            end else begin
              col_pos_nxt = col_inc[COL_W-1:0];
            end
          end
        end
        OP_DRAIN: begin
          // A drain tick with nothing pending produces no result.
          if (pend_r != '0) begin
            req.valid    = 1'b1;
            req.want_res = 1'b1;
            req.write    = 1'b0;
            req.row      = drain_row[ROW_W-1:0];
            req.dec_bank = ~cnt_eff[0];
            req.wr_bank  = 1'b0;
            req.has_left = (col_cnt_r >= COL_W'(2));
            req.up_ok    = (drain_row != '0);
            req.dn_ok    = ((drain_row + 1'b1) < len_eff);
            req.right    = CLS_BG;
            req.last     = (pend_cut == LEN_W'(1));
            pend_nxt     = pend_cut - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      pend_r    <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Class store: read, decide and write back in the cycle after the accept.
  htm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  // The store stage never stalls, so the queue must always have room for the
  // result in flight plus the one the next accepted item may bring.
  assign fifo_push = res.valid;
  assign fifo_pop  = out_valid && out_ready;
  assign in_ready  = ((FCNT_W+1)'(fifo_cnt_r) + (FCNT_W+1)'(res.valid))
                     < (FCNT_W+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_q[fifo_wr_r] <= '{edge_res: res.edge_res, last: res.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_r  <= '0;
      fifo_rd_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wr_r <= (fifo_wr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : fifo_wr_r + 1'b1;
      end
      if (fifo_pop) begin
        fifo_rd_r <= (fifo_rd_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : fifo_rd_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + FCNT_W'(fifo_push) - FCNT_W'(fifo_pop);
    end
  end

  assign out_valid    = (fifo_cnt_r != '0);
  assign out_edge_res = fifo_q[fifo_rd_r].edge_res;
  assign out_last     = fifo_q[fifo_rd_r].last;

  // A result from the store must always find a free queue slot.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push && !fifo_pop |-> fifo_cnt_r != FCNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // Every item that calls for a result gets it from the store next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && req.want_res |=> res.valid)
    else $error("result missing after accepted item");

  // The drain count never exceeds the store height.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= LEN_W'(MAX_ROWS))
    else $error("pending count out of range");

  // A pixel moves the row position one step down or back to the top.
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_PIXEL |=>
      (row_pos_r == '0) || (row_pos_r == $past(row_pos_r) + 1'b1))
    else $error("row position skipped");

endmodule

@@ sim/tb_hysteresis_threshold_mask.sv @@
// Testbench for the one-step hysteresis threshold mask.
//
// Pixels are sent in column-major order. A behavioral predictor in this file
// classifies every accepted pixel, keeps its own two-bank class store and
// positions, and queues the mask bit and end-of-image flag that each item
// should produce. The result of column c comes out while column c+1 streams
// in, and the final column comes out on drain ticks. A checker compares every
// accepted result with the oldest queued expectation.
//
// Directed tests go first, one task for each behavior: drain ticks with
// nothing pending, field extremes, a zero pixel, low above high, clamped
// register values, the pending count cut by a shorter length, a pixel that
// drops pending results, and positions wrapping after a size shrinks
// mid-image. Random images of random shape and thresholds follow, and a final
// stretch runs at full rate with no idling on either side.
module tb_hysteresis_threshold_mask;
  import htm_pkg::*;

  // Cycles allowed after the last expected result before the block counts
  // as idle; a result leaves through the class-store register and output queue.
  localparam int SETTLE_CYCLES = 4;

  // One expected result.
  typedef struct packed {
    logic edge_res;
    logic last;
  } mark_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_op;
  logic [PIX_W-1:0] in_pixel;
  logic             out_valid;
  logic             out_ready;
  logic             out_edge_res;
  logic             out_last;
  logic             cfg_wr_en;
  logic [1:0]       cfg_index;
  logic [PIX_W-1:0] cfg_data;

  // Idling switches for the sender and the receiver.
  bit send_gaps;
  bit sink_stalls;

  int items_sent;
  int results_checked;
  int error_count;

  mark_t expected_marks[$];

  // Predictor state: register copies and the block's own storage.
  logic [PIX_W-1:0] thr_low;
  logic [PIX_W-1:0] thr_high;
  logic [LEN_W-1:0] len_reg;
  logic [COL_W-1:0] cnt_reg;
  class_t           class_mem [2][MAX_ROWS];
  logic [ROW_W-1:0] row_at;
  logic [COL_W-1:0] col_at;
  logic [LEN_W-1:0] drain_left;

  hysteresis_threshold_mask DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_edge_res (out_edge_res),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Column length as the block uses it: clamped to 2..MAX_ROWS.
  function automatic int active_len();
    if (len_reg < 2) return 2;
    if (len_reg > MAX_ROWS) return MAX_ROWS;
    return int'(len_reg);
  endfunction

  // A column count of zero behaves as a single column.
  function automatic int active_cnt();
    return (cnt_reg == '0) ? 1 : int'(cnt_reg);
  endfunction

  // The low test wins, so with low above high a pixel between the two is
  // still background. A zero pixel is never weak.
  function automatic class_t classify_pixel(input logic [PIX_W-1:0] pix);
    if (pix < thr_low) return CLS_BG;
    if (pix > thr_high) return CLS_STRONG;
    return (pix != '0) ? CLS_WEAK : CLS_BG;
  endfunction

  // Mask bit of the stored pixel at (bank, row). The right neighbour has not
  // been stored yet, so its class is passed in; the left neighbour sits in
  // the other bank and exists only from the second column on.
  function automatic logic kept_mark(input int bank, input int row, input int len,
                                     input bit has_left, input class_t right);
    class_t self_cls;
    self_cls = class_mem[bank][row];
    if (self_cls == CLS_STRONG) return 1'b1;
    if (self_cls != CLS_WEAK) return 1'b0;
    if (right == CLS_STRONG) return 1'b1;
    if (row > 0 && class_mem[bank][row - 1] == CLS_STRONG) return 1'b1;
    if (row + 1 < len && class_mem[bank][row + 1] == CLS_STRONG) return 1'b1;
    if (has_left && class_mem[1 - bank][row] == CLS_STRONG) return 1'b1;
    return 1'b0;
  endfunction

  task automatic reset_predictor();
    thr_low    = '0;
    thr_high   = '1;
    len_reg    = LEN_W'(LEN_RESET);
    cnt_reg    = COL_W'(1);
    row_at     = '0;
    col_at     = '0;
    drain_left = '0;
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < MAX_ROWS; r++)
        class_mem[b][r] = CLS_BG;
  endtask

  // Advances the predictor by one accepted item and queues any result.
  task automatic predict_mask(input logic op, input logic [PIX_W-1:0] pix);
    int     len;
    int     cnt;
    int     c;
    int     r;
    class_t cls;
    mark_t  m;
    len = active_len();
    cnt = active_cnt();
    if (op == OP_DRAIN) begin
      // A drain tick with nothing pending is simply ignored.
      if (drain_left != '0) begin
        if (drain_left > len) drain_left = LEN_W'(len);
        m.edge_res = kept_mark((cnt - 1) % 2, len - int'(drain_left), len, cnt >= 2, CLS_BG);
        drain_left = drain_left - 1'b1;
        m.last     = (drain_left == '0);
        expected_marks.push_back(m);
      end
    end else begin
      cls = classify_pixel(pix);
      c   = int'(col_at);
      r   = int'(row_at);
      // Any pixel ends a pending drain; the leftover results are lost.
      drain_left = '0;
      if (c >= 1) begin
        m.edge_res = kept_mark((c - 1) % 2, r, len, c >= 2, cls);
        m.last     = 1'b0;
        expected_marks.push_back(m);
      end
      class_mem[c % 2][r] = cls;
      // Positions at or past a shrunk size wrap after this pixel.
      if (r + 1 >= len) begin
        row_at = '0;
        if (c + 1 >= cnt) begin
          col_at     = '0;
          drain_left = LEN_W'(len);
        end else begin
          col_at = COL_W'(c + 1);
        end
      end else begin
        row_at = ROW_W'(r + 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Channel drivers and the result checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Pixel values spread over all classes for the current thresholds, with
  // strong values favored so that weak pixels often find a strong neighbour.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom);
      3:       return PIX_W'($urandom_range(0, int'(thr_low)));
      4, 5:    return PIX_W'($urandom_range(int'(thr_high), 65535));
      default: return PIX_W'($urandom_range(int'(thr_low), int'(thr_high)));
    endcase
  endfunction

  // Offers one item at a falling edge, optionally after a short gap, and
  // holds it until a rising edge sees in_ready. Valid stays high on return;
  // the next call or wait_idle changes it at the following falling edge.
  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_op    = op;
    in_pixel = pix;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_mask(op, pix);
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_item(OP_PIXEL, pick_pixel());
  endtask

  // The pixel field of a drain tick is ignored, so it carries noise.
  task automatic send_drains(input int n);
    repeat (n) send_item(OP_DRAIN, PIX_W'($urandom));
  endtask

  // Drops valid and waits until every expected result has been seen, plus
  // the SETTLE_CYCLES wait for any drain tick that produced nothing.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A register write strobes cfg_wr_en; the predictor copy changes with it.
  task automatic write_reg(input logic [1:0] idx, input logic [PIX_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_LOW:     thr_low  = value;
      REG_HIGH:    thr_high = value;
      REG_COL_LEN: len_reg  = value[LEN_W-1:0];
      default:     cnt_reg  = value;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic configure_image(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi,
                                 input logic [PIX_W-1:0] len, input logic [PIX_W-1:0] cnt);
    wait_idle();
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_COL_LEN, len);
    write_reg(REG_COL_CNT, cnt);
  endtask

  // Receiver: ready drops in random bursts while stalls are enabled.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    mark_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_marks.size() == 0) begin
        report_mismatch($sformatf("unexpected result edge_res=%0b last=%0b",
                                  out_edge_res, out_last));
      end else begin
        want = expected_marks.pop_front();
        if (out_edge_res !== want.edge_res)
          report_mismatch($sformatf("result %0d: edge_res %0b, expected %0b",
                                    results_checked, out_edge_res, want.edge_res));
        if (out_last !== want.last)
          report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                    results_checked, out_last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Right after reset nothing is pending, so drain ticks give no result.
  task automatic test_empty_drain();
    send_drains(2);
  endtask

  // Three columns of four rows. Values sit on and just past both thresholds,
  // at zero and at full scale, and weak pixels see strong neighbours above,
  // below, left and right as well as none at all. One extra drain tick at
  // the end finds nothing pending.
  task automatic test_field_extremes();
    logic [PIX_W-1:0] pix [12] = '{
      16'hFFFF, 16'h0100, 16'h00FF, 16'h0000,
      16'hFF00, 16'hFF01, 16'h0001, 16'h8000,
      16'h1234, 16'h0100, 16'hFFFF, 16'h4000};
    configure_image(16'h0100, 16'hFF00, 16'd4, 16'd3);
    foreach (pix[i]) send_item(OP_PIXEL, pix[i]);
    send_drains(5);
  endtask

  // A zero pixel stays background even next to a strong one, while the
  // smallest nonzero value is weak and kept.
  task automatic test_zero_pixel();
    configure_image(16'h0000, 16'h7FFF, 16'd2, 16'd2);
    send_item(OP_PIXEL, 16'h0000);
    send_item(OP_PIXEL, 16'h8000);
    send_item(OP_PIXEL, 16'h0000);
    send_item(OP_PIXEL, 16'h0001);
    send_drains(2);
  endtask

  // With low above high, a pixel under low is background even though it is
  // above high; from low upward every pixel is strong.
  task automatic test_low_above_high();
    configure_image(16'h8000, 16'h1000, 16'd2, 16'd2);
    send_item(OP_PIXEL, 16'h0800);
    send_item(OP_PIXEL, 16'h9000);
    send_item(OP_PIXEL, 16'h8000);
    send_item(OP_PIXEL, 16'h7FFF);
    send_drains(2);
  endtask

  // Lengths of 0 and 1 act as 2 (bits above the register width are dropped),
  // a count of 0 acts as 1, and the largest length acts as MAX_ROWS. The
  // full-height column is the one long image of the run; a couple of drain
  // ticks show that it wrapped, and the next image drops the rest.
  task automatic test_size_clamps();
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    configure_image(16'h2000, 16'hC000, 16'h0000, 16'h0000);
    send_pixels(2);
    send_drains(2);
    configure_image(16'h2000, 16'hC000, 16'hF801, 16'h0000);
    send_pixels(2);
    send_drains(2);
    configure_image(16'h2000, 16'hC000, 16'h07FF, 16'd1);
    send_pixels(MAX_ROWS);
    send_drains(2);
  endtask

  // A shorter length written while results are pending cuts the pending
  // count to the new length; the drain then restarts from row zero.
  task automatic test_pending_cut();
    configure_image(16'h1000, 16'hB000, 16'd8, 16'd3);
    send_pixels(24);
    send_drains(3);
    wait_idle();
    write_reg(REG_COL_LEN, 16'd4);
    send_drains(5);
  endtask

  // A pixel arriving mid-drain drops the rest of the drain and starts the
  // next image.
  task automatic test_pixel_drops_pending();
    configure_image(16'h1000, 16'hB000, 16'd3, 16'd2);
    send_pixels(6);
    send_drains(1);
    send_pixels(6);
    send_drains(3);
  endtask

  // Sizes shrink mid-image. The row position already past the new length
  // wraps after one more pixel, and later the column position past the new
  // count wraps after its column. The sender also stops here until every
  // expected result is in.
  task automatic test_shrink_mid_image();
    configure_image(16'h1000, 16'hB000, 16'd8, 16'd3);
    send_pixels(6);
    wait_idle();
    write_reg(REG_COL_LEN, 16'd4);
    send_pixels(9);
    send_drains(4);
    configure_image(16'h1000, 16'hB000, 16'd4, 16'hFFFF);
    send_pixels(12);
    wait_idle();
    write_reg(REG_COL_CNT, 16'd2);
    send_pixels(4);
    send_drains(4);
  endtask

  // Random images: random thresholds and shapes, mostly small, with ignored
  // drain ticks sprinkled into the pixel stream and with full, partial or
  // missing drains at the end. Registers change only between images, so
  // every store entry is written before it is read.
  task automatic test_random_images(input int target);
    int               counted;
    int               npix;
    int               len;
    int               ndrain;
    int               i;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] len_data;
    logic [PIX_W-1:0] cnt_data;
    counted = 0;
    while (counted < target) begin
      case ($urandom_range(0, 5))
        0: begin
          lo = '0;
          hi = '1;
        end
        1: begin
          lo = PIX_W'($urandom);
          hi = PIX_W'($urandom);
        end
        2: begin
          lo = '1;
          hi = '0;
        end
        default: begin
          lo = PIX_W'($urandom_range(0, 32767));
          hi = PIX_W'($urandom_range(int'(lo), 65535));
        end
      endcase
      case ($urandom_range(0, 9))
        0:       len_data = PIX_W'($urandom_range(0, 1));
        1:       len_data = PIX_W'($urandom_range(11, 40));
        default: len_data = PIX_W'($urandom_range(2, 10));
      endcase
      // Bits above the register width must be ignored by the block.
      len_data[PIX_W-1:LEN_W] = (PIX_W - LEN_W)'($urandom);
      cnt_data = PIX_W'($urandom_range(0, 5));
      send_gaps   = bit'($urandom_range(0, 1));
      sink_stalls = bit'($urandom_range(0, 1));
      configure_image(lo, hi, len_data, cnt_data);
      len  = active_len();
      npix = len * active_cnt();
      for (i = 0; i < npix; i++) begin
        if (i > 0 && $urandom_range(0, 15) == 0) send_drains(1);
        send_item(OP_PIXEL, pick_pixel());
        counted++;
      end
      case ($urandom_range(0, 9))
        0:       ndrain = len + 1;
        7, 8:    ndrain = $urandom_range(1, len - 1);
        9:       ndrain = 0;
        default: ndrain = len;
      endcase
      send_drains(ndrain);
      counted += (ndrain > len) ? len : ndrain;
    end
  endtask

  // Back-to-back images at full rate: no gaps, no stalls, no pause between
  // images of the same shape.
  task automatic test_full_rate();
    int k;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    for (k = 0; k < 2; k++) begin
      configure_image(16'h3000, 16'hA000, PIX_W'($urandom_range(2, 8)),
                      PIX_W'($urandom_range(1, 4)));
      repeat (2) begin
        send_pixels(active_len() * active_cnt());
        send_drains(active_len());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_PIXEL;
    in_pixel    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_LOW;
    cfg_data    = '0;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    items_sent      = 0;
    results_checked = 0;
    error_count     = 0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_drain();
    // Idling on both sides for the short directed tests.
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    test_field_extremes();
    test_zero_pixel();
    test_low_above_high();
    test_pending_cut();
    test_pixel_drops_pending();
    test_shrink_mid_image();
    test_size_clamps();
    test_random_images(80);
    test_full_rate();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input items and %0d results, column lengths 2 to %0d,",
             items_sent, results_checked, MAX_ROWS);
    $display("counts up to 65535, thresholds at both ends and in either order.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including the full-height column.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
